/* rtl/core/fre_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the frame rate estimator.
// Used by every module of the block; depends on nothing.
package fre_pkg;

    localparam int HISTORY_DEPTH = 15;
    localparam int TIME_WIDTH    = 48;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int TPS_W         = 32;
    localparam int SF_W          = 8;
    localparam int FRAC_W        = 8;
    localparam int RATE_W        = 24;
    localparam int STAT_W        = 2;
    localparam int CNUM_W        = CNT_W + TPS_W;
    localparam int NUM_W         = CNUM_W + FRAC_W;
    localparam int PROD_W        = TIME_WIDTH + SF_W;
    localparam int DCNT_W        = $clog2(NUM_W + 1);
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
    localparam logic [TPS_W-1:0]  TPS_RESET = 32'd1000000000;
    localparam logic [SF_W-1:0]   SF_RESET  = 8'd5;

    // item kinds
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_TPS = 1'b0;
    localparam logic REG_SF  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FEW   = 2'd1,
        STATUS_STALL = 2'd2
    } status_t;

    typedef struct packed {
        logic                  action;
        logic [TIME_WIDTH-1:0] time_ticks;
    } item_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate_fixed;
        status_t           status;
        logic              against_now;
    } result_t;

    typedef struct packed {
        logic [TPS_W-1:0] ticks_per_second;
        logic [SF_W-1:0]  stall_factor;
    } cfg_t;

endpackage

/* rtl/core/fre_queue.sv */
`timescale 1ns / 1ps
// Two-entry request queue between the input channel and the back end.
// Depends on fre_pkg.
module fre_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  fre_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_pop,
    output fre_pkg::item_t out_item
);

    fre_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/core/fre_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on fre_pkg.
module fre_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [fre_pkg::NUM_W-1:0]        num,
    input  logic [fre_pkg::TIME_WIDTH-1:0]   den,
    output logic                             done,
    output logic [fre_pkg::NUM_W-1:0]        quo
);

    logic [fre_pkg::NUM_W-1:0]      num_reg;
    logic [fre_pkg::TIME_WIDTH-1:0] den_reg;
    logic [fre_pkg::TIME_WIDTH-1:0] rem_reg;
    logic [fre_pkg::DCNT_W-1:0]     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [fre_pkg::TIME_WIDTH:0]   shifted;
    logic [fre_pkg::TIME_WIDTH:0]   diff;
    logic                           ge;

    assign shifted = {rem_reg, num_reg[fre_pkg::NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign done    = done_reg;
    assign quo     = num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= fre_pkg::DCNT_W'(fre_pkg::NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - fre_pkg::DCNT_W'(1);
                if (cnt_reg == fre_pkg::DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // the dividend register shifts out its top bit and takes in quotient bits
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[fre_pkg::NUM_W-2:0], ge};
            rem_reg <= ge ? diff[fre_pkg::TIME_WIDTH-1:0] : shifted[fre_pkg::TIME_WIDTH-1:0];
        end
    end

endmodule

/* rtl/core/fre_back.sv */
`timescale 1ns / 1ps
// Back end: timestamp history, query sequencer and result register.
// Depends on fre_pkg and fre_div.
module fre_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  fre_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  fre_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output fre_pkg::result_t    m_result
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIFF = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DEC  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [fre_pkg::TIME_WIDTH-1:0] hist_reg [fre_pkg::HISTORY_DEPTH];
    logic [fre_pkg::CNT_W-1:0]      cnt_reg;
    logic [fre_pkg::CNT_W-1:0]      cnt_m1;
    logic [fre_pkg::TIME_WIDTH-1:0] oldest;
    logic [fre_pkg::TIME_WIDTH-1:0] qtime_reg;
    logic [fre_pkg::TIME_WIDTH-1:0] span_reg;
    logic [fre_pkg::TIME_WIDTH-1:0] gap_reg;
    logic [fre_pkg::TIME_WIDTH-1:0] age_reg;
    logic                           lt_reg;
    logic [fre_pkg::PROD_W-1:0]     prod_reg;
    logic [fre_pkg::CNUM_W-1:0]     cnum_reg;
    fre_pkg::result_t               res_reg, res_next;
    fre_pkg::result_t               out_reg;
    logic                           m_valid_reg;

    logic                           push_frame;
    logic                           div_start;
    logic [fre_pkg::NUM_W-1:0]      div_num;
    logic [fre_pkg::TIME_WIDTH-1:0] div_den;
    logic                           div_done;
    logic [fre_pkg::NUM_W-1:0]      div_quo;
    logic                           out_free;

    assign cnt_m1     = cnt_reg - fre_pkg::CNT_W'(1);
    assign oldest     = hist_reg[cnt_m1[fre_pkg::IDX_W-1:0]];
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign push_frame = q_pop && (q_item.action == fre_pkg::ACT_FRAME);
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_result   = out_reg;

    fre_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        div_start  = 1'b0;
        div_num    = {cnum_reg, {fre_pkg::FRAC_W{1'b0}}};
        div_den    = age_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_item.action == fre_pkg::ACT_QUERY) begin
                    if (cnt_reg < fre_pkg::CNT_W'(2)) begin
                        res_next   = '{rate_fixed: '0, status: fre_pkg::STATUS_FEW,
                                       against_now: 1'b0};
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DEC;
            ST_DEC: begin
                // rate against the newest frame, stall, or rate against the query time (RATE_MAX on a zero interval)
                if (lt_reg) begin
                    div_num = {cnum_reg - fre_pkg::CNUM_W'(cfg.ticks_per_second),
                               {fre_pkg::FRAC_W{1'b0}}};
                    div_den = span_reg;
                    res_next.against_now = 1'b0;
                end else begin
                    res_next.against_now = 1'b1;
                end
                res_next.status = fre_pkg::STATUS_OK;
                if (!lt_reg && prod_reg < fre_pkg::PROD_W'(gap_reg)) begin
                    res_next   = '{rate_fixed: '0, status: fre_pkg::STATUS_STALL,
                                   against_now: 1'b0};
                    state_next = ST_OUT;
                end else if (div_den == '0) begin
                    res_next.rate_fixed = fre_pkg::RATE_MAX;
                    state_next          = ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next.rate_fixed = (|div_quo[fre_pkg::NUM_W-1:fre_pkg::RATE_W]) ?
                                          fre_pkg::RATE_MAX : div_quo[fre_pkg::RATE_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (push_frame && cnt_reg != fre_pkg::CNT_W'(fre_pkg::HISTORY_DEPTH)) begin
                cnt_reg <= cnt_reg + fre_pkg::CNT_W'(1);
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_frame) begin
            hist_reg[0] <= q_item.time_ticks;
            for (int i = 1; i < fre_pkg::HISTORY_DEPTH; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
        if (q_pop) begin
            qtime_reg <= q_item.time_ticks;
        end
        if (state_reg == ST_DIFF) begin
            span_reg <= hist_reg[0] - oldest;
            gap_reg  <= qtime_reg - hist_reg[0];
            age_reg  <= qtime_reg - oldest;
        end
        if (state_reg == ST_MUL) begin
            lt_reg   <= (gap_reg < span_reg);
            prod_reg <= {{fre_pkg::SF_W{1'b0}}, span_reg}
                        * {{fre_pkg::TIME_WIDTH{1'b0}}, cfg.stall_factor};
            cnum_reg <= {{fre_pkg::TPS_W{1'b0}}, cnt_reg}
                        * {{fre_pkg::CNT_W{1'b0}}, cfg.ticks_per_second};
        end
        res_reg <= res_next;
        if (state_reg == ST_OUT && out_free) begin
            out_reg <= res_reg;
        end
    end

endmodule

/* rtl/core/frame_rate_estimator_core.sv */
`timescale 1ns / 1ps
// Frame rate estimator. An accepted frame waits in the queue and is shifted into the history
// once the back end is idle; a query skips the divider when stalled, at a zero interval or
// with too few frames. Frames flow at one per cycle while the back end is idle; it handles
// one request at a time, and the divider makes one quotient bit per cycle over 44 dividend bits.
// Reset (aresetn, synchronous, active low) empties the queue and the history count,
// drops any pending result and restores both registers to their defaults.
module frame_rate_estimator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // [47:0] time_ticks
    input  logic [0:0]                    s_tuser,   // [0] action
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [23:0] rate_fixed
    output logic [2:0]                    m_tuser,   // [1:0] status, [2] against_now
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fre_pkg::ADDR_W-1:0]    paddr,
    input  logic [fre_pkg::DATA_W-1:0]    pwdata,
    output logic [fre_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    fre_pkg::cfg_t    cfg_reg;
    fre_pkg::item_t   s_item;
    fre_pkg::item_t   q_item;
    fre_pkg::result_t m_result;
    logic             q_valid;
    logic             q_pop;
    logic             cfg_write;

    // Registers sit on paddr[2]; byte offset bits carry no meaning.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_second <= fre_pkg::TPS_RESET;
            cfg_reg.stall_factor     <= fre_pkg::SF_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                fre_pkg::REG_TPS: cfg_reg.ticks_per_second <= pwdata;
                fre_pkg::REG_SF:  cfg_reg.stall_factor     <= pwdata[fre_pkg::SF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        unique case (paddr[2])
            fre_pkg::REG_TPS: prdata = cfg_reg.ticks_per_second;
            fre_pkg::REG_SF:  prdata = {{(fre_pkg::DATA_W - fre_pkg::SF_W){1'b0}},
                                        cfg_reg.stall_factor};
            default:          prdata = '0;
        endcase
    end

    assign s_item.action     = s_tuser[0];
    assign s_item.time_ticks = s_tdata;

    // Front end: a two-entry queue holds requests until the back end frees up, so the
    // input side can take up to two requests during a division.
    fre_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // Back end: shift frames into the history, run queries through the
    // difference, multiply, decide and divide steps, and hold the result in
    // its own output register so the next request proceeds while it waits.
    fre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = m_result.rate_fixed;
    assign m_tuser = {m_result.against_now, m_result.status};

endmodule
